[src/rqd_pkg.sv]
// ---------------------------------------------------------------------------
// rqd_pkg
// Shared widths, pipeline depth, context type and helpers for the range
// quantize/dequantize unit.
// ---------------------------------------------------------------------------
package rqd_pkg;

    localparam int LANE_COUNT = 4;
    localparam int DATA_W     = 32;
    localparam int SPAN_W     = DATA_W + 1;
    localparam int CODE_W     = 16;
    localparam int NUM_W      = SPAN_W + CODE_W;
    localparam int BACK_W     = DATA_W;
    localparam int FOLD_N     = 8;
    localparam int CFG_IDX_W  = 4;
    // input, code divide, round, multiply, step-count fold, round, flush
    localparam int LANE_LAT   = 1 + CODE_W + 1 + 1 + FOLD_N + 1 + 1;

    localparam logic [CFG_IDX_W-1:0] CFG_LOW_BASE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_BASE = CFG_IDX_W'(LANE_COUNT);
    localparam logic [CFG_IDX_W-1:0] CFG_END       = CFG_IDX_W'(2 * LANE_COUNT);

    localparam logic [DATA_W-1:0] LOW_RESET  = DATA_W'(0);
    localparam logic [DATA_W-1:0] HIGH_RESET = DATA_W'(65536);

    localparam logic [CODE_W-1:0] STEPS_8BIT  = CODE_W'(255);
    localparam logic [CODE_W-1:0] STEPS_16BIT = CODE_W'(65535);

    // per-item context carried down each lane
    typedef struct packed {
        logic signed [DATA_W-1:0] lo;
        logic [SPAN_W-1:0]        span;
        logic                     sel;
        logic                     deg;
    } rqd_ctx_t;

    typedef logic [DATA_W-1:0] rqd_word_t;

    function automatic logic [CODE_W-1:0] steps_of(input logic sel);
        steps_of = sel ? STEPS_16BIT : STEPS_8BIT;
    endfunction

    // x * steps as shift and subtract (steps is 2^k - 1)
    function automatic logic [NUM_W-1:0] mul_steps(input logic [SPAN_W-1:0] x,
                                                   input logic sel);
        logic [NUM_W-1:0] xe;
        xe = NUM_W'(x);
        mul_steps = sel ? ((xe << 16) - xe) : ((xe << 8) - xe);
    endfunction

endpackage

[src/rqd_lane.sv]
// ---------------------------------------------------------------------------
// rqd_lane
// One lane: clamp, quantize by a bit-per-stage divider, multiply back,
// divide by the step count with a digit-sum fold, round and flush small
// values to zero.
// ---------------------------------------------------------------------------
module rqd_lane
    import rqd_pkg::*;
(
    input  logic              clk,
    input  logic              adv,
    input  logic [DATA_W-1:0] value,
    input  logic [DATA_W-1:0] lo,
    input  logic [DATA_W-1:0] hi,
    input  logic              sel,
    output logic [DATA_W-1:0] result
);

    rqd_ctx_t          ctx_reg  [0:LANE_LAT-2];
    logic [NUM_W-1:0]  rem1_reg [0:CODE_W];
    logic [CODE_W-1:0] q1_reg   [1:CODE_W];
    logic [CODE_W-1:0] code_reg;
    logic [NUM_W-1:0]  rem2_reg [0:FOLD_N];
    logic [BACK_W-1:0] q2_reg   [0:FOLD_N];
    logic signed [SPAN_W:0] rest_reg;
    logic [DATA_W-1:0] result_reg;

    // input stage: span, clamp, offset, numerator
    logic signed [SPAN_W-1:0] lo_x, hi_x, val_x, span_x, clamp_x, d_x;
    rqd_ctx_t ctx_next;
    always_comb
    begin
        lo_x   = SPAN_W'(signed'(lo));
        hi_x   = SPAN_W'(signed'(hi));
        val_x  = SPAN_W'(signed'(value));
        span_x = hi_x - lo_x;
        clamp_x = val_x;
        if (clamp_x < lo_x)
        begin
            clamp_x = lo_x;
        end
        if (clamp_x > hi_x)
        begin
            clamp_x = hi_x;
        end
        d_x = clamp_x - lo_x;
        ctx_next.lo   = signed'(lo);
        ctx_next.span = span_x;
        ctx_next.sel  = sel;
        ctx_next.deg  = span_x[SPAN_W-1] || (span_x == '0);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctx_reg[0]  <= ctx_next;
            rem1_reg[0] <= mul_steps(d_x, sel);
        end
    end

    // context follows the item down the lane
    for (genvar s = 1; s < LANE_LAT - 1; s++)
    begin : g_ctx
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                ctx_reg[s] <= ctx_reg[s-1];
            end
        end
    end

    // code divider: one quotient bit per stage, MSB first
    for (genvar j = 0; j < CODE_W; j++)
    begin : g_div1
        logic [NUM_W-1:0] trial;
        logic             ge;
        logic [CODE_W-1:0] q_prev;
        always_comb
        begin
            trial = NUM_W'(ctx_reg[j].span) << (CODE_W - 1 - j);
            ge    = rem1_reg[j] >= trial;
        end
        if (j == 0)
        begin : g_first
            assign q_prev = '0;
        end
        else
        begin : g_rest
            assign q_prev = q1_reg[j];
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem1_reg[j+1] <= ge ? rem1_reg[j] - trial : rem1_reg[j];
                q1_reg[j+1]   <= {q_prev[CODE_W-2:0], ge};
            end
        end
    end

    // round code to nearest, ties to even
    localparam int S_RND1 = CODE_W;
    logic [SPAN_W:0] twice1;
    logic            inc1;
    always_comb
    begin
        twice1 = {rem1_reg[CODE_W][SPAN_W-1:0], 1'b0};
        inc1   = (twice1 > {1'b0, ctx_reg[S_RND1].span}) ||
                 ((twice1 == {1'b0, ctx_reg[S_RND1].span}) && q1_reg[CODE_W][0]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            code_reg <= q1_reg[CODE_W] + CODE_W'(inc1);
        end
    end

    // code times span
    localparam int S_MUL = CODE_W + 1;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem2_reg[0] <= NUM_W'(code_reg) * NUM_W'(ctx_reg[S_MUL].span);
            q2_reg[0]   <= '0;
        end
    end

    // divide by 2^k - 1: a*2^k + b = a*(2^k - 1) + (a + b), so each stage
    // moves the high part into the quotient and folds it into the remainder
    localparam int S_DIV2 = CODE_W + 2;
    for (genvar j = 0; j < FOLD_N; j++)
    begin : g_fold
        logic [NUM_W-1:0] hi_part;
        logic [NUM_W-1:0] lo_part;
        always_comb
        begin
            if (ctx_reg[S_DIV2+j].sel)
            begin
                hi_part = rem2_reg[j] >> 16;
            end
            else
            begin
                hi_part = rem2_reg[j] >> 8;
            end
            lo_part = rem2_reg[j] & NUM_W'(steps_of(ctx_reg[S_DIV2+j].sel));
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem2_reg[j+1] <= hi_part + lo_part;
                q2_reg[j+1]   <= q2_reg[j] + hi_part[BACK_W-1:0];
            end
        end
    end

    // round restored offset and add the low bound; a remainder equal to
    // the step count also rounds up, giving the exact quotient
    localparam int S_RND2 = S_DIV2 + FOLD_N;
    logic [CODE_W:0]      twice2;
    logic [CODE_W:0]      steps2;
    logic                 inc2;
    logic [SPAN_W-1:0]    back;
    always_comb
    begin
        steps2 = {1'b0, steps_of(ctx_reg[S_RND2].sel)};
        twice2 = {rem2_reg[FOLD_N][CODE_W-1:0], 1'b0};
        inc2   = (twice2 > steps2) || ((twice2 == steps2) && q2_reg[FOLD_N][0]);
        back   = SPAN_W'(q2_reg[FOLD_N]) + SPAN_W'(inc2);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rest_reg <= signed'({1'b0, back}) + (SPAN_W+1)'(ctx_reg[S_RND2].lo);
        end
    end

    // flush values under one step, degenerate span gives low
    localparam int S_FL = S_RND2 + 1;
    logic signed [SPAN_W:0] neg;
    logic [SPAN_W-1:0]      mag;
    logic                   tiny;
    always_comb
    begin
        neg  = -rest_reg;
        mag  = rest_reg[SPAN_W] ? neg[SPAN_W-1:0] : rest_reg[SPAN_W-1:0];
        tiny = mul_steps(mag, ctx_reg[S_FL].sel) < NUM_W'(ctx_reg[S_FL].span);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (ctx_reg[S_FL].deg)
            begin
                result_reg <= ctx_reg[S_FL].lo;
            end
            else if (tiny)
            begin
                result_reg <= '0;
            end
            else
            begin
                result_reg <= rest_reg[DATA_W-1:0];
            end
        end
    end

    assign result = result_reg;

endmodule

[src/rqd_merge.sv]
// ---------------------------------------------------------------------------
// rqd_merge
// Joins the lanes: tracks item valid down the shared pipeline, presents
// the lane results as one output transfer and stalls all lanes together.
// ---------------------------------------------------------------------------
module rqd_merge
    import rqd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output logic      adv,
    input  rqd_word_t lane_result [LANE_COUNT],
    output rqd_word_t merged      [LANE_COUNT]
);

    logic [LANE_LAT-1:0] valid_reg;
    logic [LANE_LAT-1:0] valid_next;

    // whole pipeline moves unless the last stage holds an untaken result
    assign adv = !valid_reg[LANE_LAT-1] || out_ready;

    always_comb
    begin
        valid_next = {valid_reg[LANE_LAT-2:0], in_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= valid_next;
        end
    end

    for (genvar l = 0; l < LANE_COUNT; l++)
    begin : g_out
        assign merged[l] = lane_result[l];
    end

    assign in_ready  = adv;
    assign out_valid = valid_reg[LANE_LAT-1];

endmodule

[src/range_quantize_dequantize_unit.sv]
// ---------------------------------------------------------------------------
// range_quantize_dequantize_unit
// Four-lane uniform quantize/dequantize of Q16.16 values over per-lane
// configured bounds, 8-bit or 16-bit steps.
// ---------------------------------------------------------------------------
// Accepts one four-lane item per cycle while the output is not stalled. Each
// result passes through the lane pipeline: an input stage, a 16-stage code
// divider (one bit a stage), a rounding stage, a multiply stage, an 8-stage
// fold that divides by the step count, a rounding stage and a flush stage.
// All lanes stall together while an output waits.
// Configuration writes are taken every cycle and must only be made while
// the unit is empty; writes to an index past the high bounds are dropped.
module range_quantize_dequantize_unit
    import rqd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [DATA_W-1:0]    value_lane0,
    input  logic [DATA_W-1:0]    value_lane1,
    input  logic [DATA_W-1:0]    value_lane2,
    input  logic [DATA_W-1:0]    value_lane3,
    input  logic                 precision_select,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [DATA_W-1:0]    result_lane0,
    output logic [DATA_W-1:0]    result_lane1,
    output logic [DATA_W-1:0]    result_lane2,
    output logic [DATA_W-1:0]    result_lane3,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data
);

    rqd_word_t low_reg  [LANE_COUNT];
    rqd_word_t high_reg [LANE_COUNT];
    rqd_word_t values   [LANE_COUNT];
    rqd_word_t lane_res [LANE_COUNT];
    rqd_word_t merged   [LANE_COUNT];
    logic      adv;

    // configuration registers
    assign cfg_ready = 1'b1;

    for (genvar l = 0; l < LANE_COUNT; l++)
    begin : g_cfg
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                low_reg[l]  <= LOW_RESET;
                high_reg[l] <= HIGH_RESET;
            end
            else if (cfg_valid)
            begin
                if (cfg_index == CFG_LOW_BASE + CFG_IDX_W'(l))
                begin
                    low_reg[l] <= cfg_data;
                end
                if (cfg_index == CFG_HIGH_BASE + CFG_IDX_W'(l) && cfg_index < CFG_END)
                begin
                    high_reg[l] <= cfg_data;
                end
            end
        end
    end

    assign values[0] = value_lane0;
    assign values[1] = value_lane1;
    assign values[2] = value_lane2;
    assign values[3] = value_lane3;

    // lanes
    for (genvar l = 0; l < LANE_COUNT; l++)
    begin : g_lane
        rqd_lane u_lane (
            .clk    (clk),
            .adv    (adv),
            .value  (values[l]),
            .lo     (low_reg[l]),
            .hi     (high_reg[l]),
            .sel    (precision_select),
            .result (lane_res[l])
        );
    end

    rqd_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .adv         (adv),
        .lane_result (lane_res),
        .merged      (merged)
    );

    assign result_lane0 = merged[0];
    assign result_lane1 = merged[1];
    assign result_lane2 = merged[2];
    assign result_lane3 = merged[3];

    // input side stalls only behind a waiting output
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no output pending");

    // a new output appears only after the pipeline moved
    a_out_after_advance: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_ready))
        else $error("output appeared without pipeline advance");

endmodule

[tb/sv/range_quantize_dequantize_unit_tb.sv]
// ---------------------------------------------------------------------------
// range_quantize_dequantize_unit_tb
// Streams four-lane Q16.16 items through the quantize/dequantize unit under
// several bound settings and handshake pressure, and checks every result
// against an exact integer prediction of clamp, quantize, restore and flush.
// ---------------------------------------------------------------------------
module range_quantize_dequantize_unit_tb
    import rqd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_WAIT  = LANE_LAT + 20;
    localparam int LANE_IDX_W  = $clog2(LANE_COUNT);

    typedef struct packed {
        logic [3:0][DATA_W-1:0] value;
        logic                   sel;
    } lane_item_t;

    typedef logic [3:0][DATA_W-1:0] lane_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [DATA_W-1:0] value_lane0 = '0, value_lane1 = '0, value_lane2 = '0, value_lane3 = '0;
    logic precision_select = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [DATA_W-1:0] result_lane0, result_lane1, result_lane2, result_lane3;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0] cfg_data = '0;

    // bounds as the unit holds them
    logic signed [DATA_W-1:0] bound_lo [LANE_COUNT];
    logic signed [DATA_W-1:0] bound_hi [LANE_COUNT];

    lane_item_t   pending_items [$];
    lane_result_t restored_expected [$];
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  mismatch_count = 0;
    int  items_sent = 0;
    int  driven_count = 0;
    int  results_seen = 0;
    int  quiet_cycles = 0;
    bit  timed_out = 1'b0;

    range_quantize_dequantize_unit DUT (.*);

    always #2 clk = ~clk;

    // nearest integer of num / den, halves to even
    function automatic longint unsigned div_half_even(longint unsigned num,
                                                      longint unsigned den);
        longint unsigned q, r;
        q = num / den;
        r = num % den;
        if (2 * r > den || (2 * r == den && q[0]))
            q++;
        return q;
    endfunction

    function automatic logic [DATA_W-1:0] restore_lane(logic signed [DATA_W-1:0] x,
                                                       logic signed [DATA_W-1:0] lo,
                                                       logic signed [DATA_W-1:0] hi,
                                                       logic sel);
        longint v, span, restored, mag;
        longint unsigned steps, code;
        steps = sel ? 65535 : 255;
        span = longint'(hi) - longint'(lo);
        if (span <= 0)
            return lo;
        v = x;
        if (v < lo) v = lo;
        if (v > hi) v = hi;
        code = div_half_even(longint'(v - lo) * steps, span);
        restored = longint'(div_half_even(code * span, steps)) + lo;
        mag = restored < 0 ? -restored : restored;
        if (mag * longint'(steps) < span)
            return '0;
        return restored[DATA_W-1:0];
    endfunction

    function automatic lane_result_t quantize_item(lane_item_t it);
        lane_result_t r;
        for (int i = 0; i < LANE_COUNT; i++)
            r[i] = restore_lane(it.value[i], bound_lo[i], bound_hi[i], it.sel);
        return r;
    endfunction

    task automatic report_mismatch(string what, int lane, logic [DATA_W-1:0] got,
                                   logic [DATA_W-1:0] want);
        mismatch_count++;
        $display("MISMATCH %s lane %0d: got %h want %h", what, lane, got, want);
    endtask

    // driver: input side; an item is held until the monitor saw its transfer
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || items_sent == driven_count)
            begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    value_lane0 <= pending_items[0].value[0];
                    value_lane1 <= pending_items[0].value[1];
                    value_lane2 <= pending_items[0].value[2];
                    value_lane3 <= pending_items[0].value[3];
                    precision_select <= pending_items[0].sel;
                    driven_count <= driven_count + 1;
                end
                else
                    in_valid <= 1'b0;
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor: predict on input transfer, check on output transfer
    always @(posedge clk)
    begin
        lane_result_t got, want;
        bit moved;
        if (rst_n)
        begin
            moved = (in_valid && in_ready) || (cfg_valid && cfg_ready)
                    || (out_valid && out_ready);
            quiet_cycles <= moved ? 0 : quiet_cycles + 1;
            if (in_valid && in_ready)
            begin
                restored_expected.push_back(quantize_item(pending_items[0]));
                void'(pending_items.pop_front());
                items_sent <= items_sent + 1;
            end
            if (out_valid && out_ready)
            begin
                results_seen <= results_seen + 1;
                got = {result_lane3, result_lane2, result_lane1, result_lane0};
                if (restored_expected.size() == 0)
                begin
                    report_mismatch("unexpected result", 0, got[0], '0);
                end
                else
                begin
                    want = restored_expected.pop_front();
                    for (int i = 0; i < LANE_COUNT; i++)
                        if (got[i] !== want[i])
                            report_mismatch("result", i, got[i], want[i]);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (quiet_cycles >= STALL_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("timeout after %0d idle cycles", quiet_cycles);
            $display("status: fail");
            $finish;
        end
    end

    task automatic write_bound(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
        logic [CFG_IDX_W-1:0] rel;
        rel = idx - CFG_HIGH_BASE;
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx < CFG_HIGH_BASE)
            bound_lo[idx[LANE_IDX_W-1:0]] = data;
        else if (idx < CFG_END)
            bound_hi[rel[LANE_IDX_W-1:0]] = data;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_bounds(logic [DATA_W-1:0] lo [LANE_COUNT],
                              logic [DATA_W-1:0] hi [LANE_COUNT]);
        for (int i = 0; i < LANE_COUNT; i++)
        begin
            write_bound(CFG_LOW_BASE + CFG_IDX_W'(i), lo[i]);
            write_bound(CFG_HIGH_BASE + CFG_IDX_W'(i), hi[i]);
        end
    endtask

    task automatic wait_drained();
        while (pending_items.size() > 0 || restored_expected.size() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // value near a lane's bounds, or anywhere
    function automatic logic [DATA_W-1:0] pick_value(int lane);
        case ($urandom_range(5))
            0: return bound_lo[lane] + DATA_W'($urandom_range(4)) - 2;
            1: return bound_hi[lane] + DATA_W'($urandom_range(4)) - 2;
            2: return $urandom;
            3: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
            default:
                if (longint'(bound_hi[lane]) >= longint'(bound_lo[lane]))
                    return bound_lo[lane]
                        + DATA_W'($urandom % (longint'(bound_hi[lane]) - bound_lo[lane] + 1));
                else
                    return bound_lo[lane];
        endcase
    endfunction

    task automatic queue_random(int count);
        lane_item_t it;
        for (int n = 0; n < count; n++)
        begin
            for (int i = 0; i < LANE_COUNT; i++)
                it.value[i] = pick_value(i);
            it.sel = 1'($urandom_range(1));
            pending_items.push_back(it);
        end
    endtask

    task automatic random_bounds();
        logic [DATA_W-1:0] lo [LANE_COUNT], hi [LANE_COUNT];
        for (int i = 0; i < LANE_COUNT; i++)
        begin
            case ($urandom_range(4))
                0: begin lo[i] = 32'h8000_0000; hi[i] = 32'h7FFF_FFFF; end
                1: begin lo[i] = $urandom; hi[i] = $urandom; end
                2: begin lo[i] = -$urandom_range(300000); hi[i] = $urandom_range(300000); end
                3: begin lo[i] = $urandom_range(1000); hi[i] = lo[i] + $urandom_range(300); end
                default: begin lo[i] = -$urandom_range(1 << 20); hi[i] = lo[i]; end
            endcase
        end
        set_bounds(lo, hi);
    endtask

    initial
    begin
        lane_item_t it;
        logic [DATA_W-1:0] lo [LANE_COUNT], hi [LANE_COUNT];
        logic [DATA_W-1:0] edge_vals [8];
        for (int i = 0; i < LANE_COUNT; i++)
        begin
            bound_lo[i] = LOW_RESET;
            bound_hi[i] = HIGH_RESET;
        end
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: reset bounds, extremes, both precisions, ties and flush
        edge_vals = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF,
                      32'h0000_0080, 32'h0000_8000, 32'h0001_0000, 32'h0000_0101};
        for (int k = 0; k < 8; k++)
            for (int s = 0; s < 2; s++)
            begin
                for (int i = 0; i < LANE_COUNT; i++)
                    it.value[i] = edge_vals[(k + i) % 8];
                it.sel = s[0];
                pending_items.push_back(it);
            end
        wait_drained();

        // full range, inverted span, equal bounds, tiny span
        lo = '{32'h8000_0000, 32'h0001_0000, 32'h0000_5000, 32'hFFFF_FF00};
        hi = '{32'h7FFF_FFFF, 32'hFFFF_0000, 32'h0000_5000, 32'h0000_0100};
        set_bounds(lo, hi);
        for (int k = 0; k < 8; k++)
        begin
            for (int i = 0; i < LANE_COUNT; i++)
                it.value[i] = edge_vals[(k * 3 + i) % 8];
            it.sel = k[0];
            pending_items.push_back(it);
        end
        wait_drained();
        // write to a dropped index must not disturb the bounds
        write_bound(CFG_END, 32'h1234_5678);

        // random phases with changing pressure
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
                default: begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            random_bounds();
            queue_random(90);
            wait_drained();
        end

        $display("covered %0d items, %0d results, 8 random bound settings", items_sent,
                 results_seen);
        $display("pressure phases: none, sender idle, receiver stall, both");
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
